[src/clbs_pkg.sv]
// Shared types, codes and sequencing tables for the character LCD bus sequencer.
package clbs_pkg;

  // Request kinds as they arrive on the input word.
  localparam logic [2:0] KIND_COMMAND = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_GOTO    = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_INIT    = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MASK   = 2'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Controller command bytes.
  localparam logic [7:0] CMD_FUNC8    = 8'h38;
  localparam logic [7:0] CMD_START4_A = 8'h33;
  localparam logic [7:0] CMD_START4_B = 8'h32;
  localparam logic [7:0] CMD_FUNC4    = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0E;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ROW0_BASE    = 8'h80;
  localparam logic [7:0] ROW1_BASE    = 8'hC0;
  localparam logic [7:0] NIBBLE_MASK  = 8'hF0;

  // Hold times in microseconds.
  localparam logic [15:0] HOLD_POWER_UP = 16'd40000;
  localparam logic [15:0] HOLD_CLEAR    = 16'd2000;
  localparam logic [15:0] HOLD_SETTLE   = 16'd1000;
  localparam logic [15:0] HOLD_FRAME    = 16'd20;
  localparam logic [15:0] HOLD_STROBE2  = 16'd2;
  localparam logic [15:0] HOLD_STROBE1  = 16'd1;
  localparam logic [15:0] HOLD_NONE     = 16'd0;

  // Input word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] display_number;
    logic [7:0] byte_value;
    logic [7:0] row;
    logic [7:0] column;
  } in_t;

  // Output word: one timed pin segment.
  typedef struct packed {
    logic [2:0]  display_index;
    logic        reg_select;
    logic        read_write;
    logic        enable_pin;
    logic [7:0]  data_bus;
    logic [15:0] hold_us;
    logic        status;
    logic        last;
  } out_t;

  // Job classes handed from the front end to the sequencer.
  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_BYTE,
    JOB_CLEAR,
    JOB_INIT
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] disp;
    logic       rs;
    logic       nib;
    logic [7:0] byte_v;
  } job_t;

  // Queue head as seen by the sequencer.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // One step of a job: either a pure delay or a byte transfer.
  typedef struct packed {
    logic        is_pause;
    logic [15:0] hold;
    logic [7:0]  byte_v;
    logic        last;
  } step_t;

  localparam int unsigned STEP_IDX_W = 3;

  // Step table for every job class; error jobs are handled by the sequencer directly.
  function automatic step_t step_f(job_kind_e kind, logic nib,
                                   logic [STEP_IDX_W-1:0] idx, logic [7:0] b);
    step_t s;
    s = '{is_pause: 1'b1, hold: HOLD_NONE, byte_v: 8'h00, last: 1'b1};
    unique case (kind)
      JOB_BYTE: begin
        s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: b, last: 1'b1};
      end
      JOB_CLEAR: begin
        unique case (idx)
          3'd0:    s = '{is_pause: 1'b1, hold: HOLD_FRAME, byte_v: 8'h00, last: 1'b0};
          3'd1:    s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_CLEAR, last: 1'b0};
          default: s = '{is_pause: 1'b1, hold: HOLD_FRAME, byte_v: 8'h00, last: 1'b1};
        endcase
      end
      JOB_INIT: begin
        if (nib) begin
          unique case (idx)
            3'd0: s = '{is_pause: 1'b1, hold: HOLD_POWER_UP, byte_v: 8'h00, last: 1'b0};
            3'd1: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_START4_A, last: 1'b0};
            3'd2: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_START4_B, last: 1'b0};
            3'd3: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_FUNC4, last: 1'b0};
            3'd4: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_DISP_ON, last: 1'b0};
            3'd5: s = '{is_pause: 1'b1, hold: HOLD_SETTLE, byte_v: 8'h00, last: 1'b0};
            3'd6: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_CLEAR, last: 1'b0};
            default: s = '{is_pause: 1'b1, hold: HOLD_CLEAR, byte_v: 8'h00, last: 1'b1};
          endcase
        end else begin
          unique case (idx)
            3'd0: s = '{is_pause: 1'b1, hold: HOLD_POWER_UP, byte_v: 8'h00, last: 1'b0};
            3'd1: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_FUNC8, last: 1'b0};
            3'd2: s = '{is_pause: 1'b1, hold: HOLD_SETTLE, byte_v: 8'h00, last: 1'b0};
            3'd3: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_DISP_ON, last: 1'b0};
            3'd4: s = '{is_pause: 1'b1, hold: HOLD_SETTLE, byte_v: 8'h00, last: 1'b0};
            3'd5: s = '{is_pause: 1'b0, hold: HOLD_NONE, byte_v: CMD_CLEAR, last: 1'b0};
            default: s = '{is_pause: 1'b1, hold: HOLD_CLEAR, byte_v: 8'h00, last: 1'b1};
          endcase
        end
      end
      default: begin
        s = '{is_pause: 1'b1, hold: HOLD_NONE, byte_v: 8'h00, last: 1'b1};
      end
    endcase
    return s;
  endfunction

endpackage

[src/clbs_front.sv]
// Front end: configuration registers, request acceptance and classification into jobs.
module clbs_front #(
  parameter int unsigned MAX_DISPLAYS = 8,
  parameter int unsigned LAST_COLUMN  = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [clbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  clbs_pkg::in_t                      in_word_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output clbs_pkg::job_t                     push_job_o
);
  import clbs_pkg::*;

  localparam logic [3:0] MaxCount = 4'(MAX_DISPLAYS);
  localparam logic [7:0] LastCol  = 8'(LAST_COLUMN);

  logic [3:0] display_count_q;
  logic [7:0] nibble_mode_mask_q;
  logic [3:0] eff_count;
  logic       bad;
  logic       kind_ok;
  logic [7:0] goto_byte;
  job_t       job;

  // Configuration registers; user writes only while the block is idle, not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_count_q    <= 4'd1;
      nibble_mode_mask_q <= 8'h00;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_DISPLAY_COUNT) begin
        display_count_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == REG_NIBBLE_MASK) begin
        nibble_mode_mask_q <= cfg_data_i;
      end
    end
  end

  // Range checks and byte selection for the request.
  always_comb begin
    eff_count = (display_count_q > MaxCount) ? MaxCount : display_count_q;
    bad       = in_word_i.display_number >= {4'd0, eff_count};
    if (in_word_i.kind == KIND_GOTO &&
        (in_word_i.row > 8'd1 || in_word_i.column > LastCol)) begin
      bad = 1'b1;
    end
    kind_ok   = in_word_i.kind <= KIND_INIT;
    goto_byte = ((in_word_i.row != 8'd0) ? ROW1_BASE : ROW0_BASE) + in_word_i.column;

    job.disp   = in_word_i.display_number[2:0];
    job.nib    = nibble_mode_mask_q[in_word_i.display_number[2:0]];
    job.rs     = 1'b0;
    job.byte_v = in_word_i.byte_value;
    job.kind   = JOB_BYTE;
    if (bad) begin
      job.kind = JOB_ERR;
    end else begin
      priority case (in_word_i.kind)
        KIND_DATA:  job.rs = 1'b1;
        KIND_GOTO:  job.byte_v = goto_byte;
        KIND_CLEAR: job.kind = JOB_CLEAR;
        KIND_INIT:  job.kind = JOB_INIT;
        default:    job.kind = JOB_BYTE;
      endcase
    end
  end

  // Unused kinds are taken and dropped; the rest go to the queue.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && kind_ok;
  assign push_job_o = job;

endmodule

[src/clbs_queue.sv]
// Short job queue between the front end and the segment sequencer.
module clbs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clbs_pkg::job_t   push_job_i,
  output logic             full_o,
  input  logic             pop_i,
  output clbs_pkg::head_t  head_o
);
  import clbs_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign full_o       = count_q == CntW'(Depth);
  assign head_o.valid = count_q != '0;
  assign head_o.job   = mem_q[rd_ptr_q];

endmodule

[src/clbs_back.sv]
// Back end: walks jobs' steps and phases, one pin segment a cycle if not stalled.
module clbs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clbs_pkg::head_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output clbs_pkg::out_t   out_word_o
);
  import clbs_pkg::*;

  logic [STEP_IDX_W-1:0] step_q;
  logic [1:0]            phase_q;
  logic                  out_valid_q;
  out_t                  out_q;
  step_t                 st;
  out_t                  seg;
  logic [1:0]            byte_end;
  logic                  step_done;
  logic                  advance;
  job_t                  job;

  // Segment for the current step and phase of the head job.
  always_comb begin
    job      = head_i.job;
    st       = step_f(job.kind, job.nib, step_q, job.byte_v);
    byte_end = job.nib ? 2'd3 : 2'd1;

    seg               = '0;
    seg.display_index = job.disp;
    if (job.kind == JOB_ERR) begin
      seg.status = 1'b1;
      seg.last   = 1'b1;
      step_done  = 1'b1;
    end else if (st.is_pause) begin
      seg.hold_us = st.hold;
      seg.last    = st.last;
      step_done   = 1'b1;
    end else begin
      seg.reg_select = job.rs;
      if (job.nib) begin
        // High nibble first, then low nibble, each strobed then settled.
        seg.data_bus   = phase_q[1] ? {st.byte_v[3:0], 4'h0} : (st.byte_v & NIBBLE_MASK);
        seg.enable_pin = !phase_q[0];
        seg.hold_us    = phase_q[0] ? HOLD_STROBE2 : HOLD_STROBE1;
      end else begin
        seg.data_bus   = st.byte_v;
        seg.enable_pin = phase_q == 2'd0;
        seg.hold_us    = (phase_q == 2'd0) ? HOLD_STROBE2 : HOLD_NONE;
      end
      step_done = phase_q == byte_end;
      seg.last  = st.last && step_done;
    end
  end

  assign advance = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && seg.last;

  // Step counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      if (seg.last) begin
        step_q  <= '0;
        phase_q <= '0;
      end else if (step_done) begin
        step_q  <= step_q + 1'b1;
        phase_q <= '0;
      end else begin
        phase_q <= phase_q + 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= seg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[src/char_lcd_bus_sequencer.sv]
// Top level of the character LCD bus sequencer.
//
// Requests arrive on the input channel as one word (kind, display number, byte,
// row, column) under valid/stall; a word is taken when valid is high and stall low.
// Each request becomes a run of timed pin segments on the output channel, one word
// per segment, the final one flagged by last. Out-of-range requests give a single
// word with status set; kinds above initialise are taken and give nothing.
// The front end classifies a request in the cycle it is taken and places it in a
// two-entry job queue; the sequencer emits one segment per cycle from the queue
// head while the receiver does not stall, and a request passes through the queue
// and the output register before its first segment appears. A byte request gives
// four segments on a 4-bit display and two on an 8-bit one; a clear gives four or
// six, an initialise ten or twenty-three; the sequencer sets the sustained rate.
// When the receiver stalls, the output word holds and the sequencer waits; the
// input side keeps taking requests until the queue is full.
// Reset clears the queue and the sequencer and sets the display count to one and
// every display to the 8-bit bus. Configuration writes are taken at any edge with
// the write enable high and must be made while the block is idle.
module char_lcd_bus_sequencer #(
  parameter int unsigned MAX_DISPLAYS = 8,
  parameter int unsigned LAST_COLUMN  = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  clbs_pkg::in_t                    in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output clbs_pkg::out_t                   out_word_o
);
  import clbs_pkg::*;

  logic  push;
  job_t  push_job;
  logic  q_full;
  logic  pop;
  head_t head;

  // Request acceptance and classification.
  clbs_front #(
    .MAX_DISPLAYS (MAX_DISPLAYS),
    .LAST_COLUMN  (LAST_COLUMN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  // Job queue.
  clbs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Segment sequencer.
  clbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[src/clbs_checker.sv]
// Port-level checks on the output channel of the sequencer, bound to the top level.
module clbs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input clbs_pkg::out_t out_word_o
);

  // A stalled word stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // An error word is the whole answer to its request and drives nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status |->
      out_word_o.last && !out_word_o.enable_pin && out_word_o.hold_us == 16'd0)
    else $error("error word malformed");

  // A strobe-high segment is always followed by its falling edge, never ends a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.enable_pin |-> !out_word_o.last)
    else $error("request ended with E high");

  // The bus is only ever written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_word_o.read_write)
    else $error("read cycle driven");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (.*);
